### rtl/core/pls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    // Fixed field widths of the stream beats
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;  // shift up from position, load word at position
        logic             rem;  // shift down from position
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

### rtl/core/pls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds a word, takes from its lower or upper neighbor.
// ----------------------------------------------------------------------------
module pls_cell
    import pls_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [WORD_WIDTH-1:0] i_new_word,
    input  logic [WORD_WIDTH-1:0] i_prev_word,
    input  logic [WORD_WIDTH-1:0] i_next_word,
    output logic [WORD_WIDTH-1:0] o_word,
    output logic [WORD_WIDTH-1:0] o_rd_word
);

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;
    logic [31:0]           w_pos;
    logic                  w_at;
    logic                  w_above;

    assign w_pos   = 32'(i_ctrl.pos);
    assign w_at    = (w_pos == IDX);
    assign w_above = (IDX > w_pos);

    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (w_at) begin
                n_word = i_new_word;
            end else if (w_above) begin
                n_word = i_prev_word;
            end
        end else if (i_ctrl.rem) begin
            if (w_at || w_above) begin
                n_word = i_next_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = w_at ? r_word : '0;

endmodule

### rtl/core/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered word list with insert, remove and read at a position,
// built as a chain of cells that shift in parallel.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake              | Payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: opcode, position, word_in
//  m_axis   | out | m_axis_tvalid/tready   | tdata: word_out, count_out;
//           |     |                        | tuser: error
//
//  One request per cycle while the result is not stalled: every cell moves
//  in the same cycle, so an insert or remove shifts the chain at once. The
//  result beat follows in the next cycle, held in an output register.
//  Reset clears the count and the result valid flag; the result payload and
//  the cell contents stay undefined until written.
//  A stalled result blocks the input only while it is not being taken.
// ----------------------------------------------------------------------------
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] opcode, [6:2] position, [38:7] word_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] word_out, [36:32] count_out
    output logic        m_axis_tuser    // [0] error
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    // Request fields
    logic [1:0]            w_opcode;
    logic [POS_W-1:0]      w_pos;
    logic [WORD_WIDTH-1:0] w_word;
    logic                  w_accept;

    assign w_opcode = s_axis_tdata[1:0];
    assign w_pos    = s_axis_tdata[6:2];
    assign w_word   = WORD_WIDTH'(s_axis_tdata[38:7]);

    // Count and output register
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_word_out;
    logic              r_error;
    logic [CNT_W-1:0]  r_count_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Range checks
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic             w_full;
    logic             w_err;
    logic             w_do_ins;
    logic             w_do_rem;
    logic             w_do_rd;

    assign w_pos_x = CMP_W'(w_pos);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_full  = (r_count == CW'(CAPACITY));

    always_comb begin
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_do_rd  = 1'b0;
        w_err    = 1'b1;
        case (t_opcode'(w_opcode))
            OP_INSERT: begin
                w_err    = (w_pos_x > w_cnt_x) || w_full;
                w_do_ins = !w_err;
            end
            OP_REMOVE: begin
                w_err    = (w_pos_x >= w_cnt_x);
                w_do_rem = !w_err;
            end
            OP_READ: begin
                w_err   = (w_pos_x >= w_cnt_x);
                w_do_rd = !w_err;
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_accept && w_do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_accept && w_do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // Cell chain: broadcast control, neighbors wired in a row
    t_cell_ctrl            w_ctrl;
    logic [WORD_WIDTH-1:0] w_cell_word [CAPACITY];
    logic [WORD_WIDTH-1:0] w_cell_rd   [CAPACITY];
    logic [WORD_WIDTH-1:0] w_rd_word;

    assign w_ctrl.ins = w_accept && w_do_ins;
    assign w_ctrl.rem = w_accept && w_do_rem;
    assign w_ctrl.pos = w_pos;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_prev;
        logic [WORD_WIDTH-1:0] w_next;

        // Bottom cell never shifts up; top cell has nothing above to pull
        assign w_prev = (g == 0) ? w_cell_word[0] : w_cell_word[(g == 0) ? 0 : g - 1];
        assign w_next = (g == CAPACITY - 1) ? w_cell_word[g]
                                            : w_cell_word[(g == CAPACITY - 1) ? g : g + 1];

        pls_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_new_word  (w_word),
            .i_prev_word (w_prev),
            .i_next_word (w_next),
            .o_word      (w_cell_word[g]),
            .o_rd_word   (w_cell_rd[g])
        );
    end

    // Only the addressed cell drives nonzero, so OR the read taps
    always_comb begin
        w_rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_word = w_rd_word | w_cell_rd[k];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted request beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word_out  <= w_do_rd ? DATA_W'(w_rd_word) : '0;
            r_error     <= w_err;
            r_count_out <= CNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_count_out, r_word_out};
    assign m_axis_tuser  = r_error;

    // Checks
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_do_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_error_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_err) |=> (r_count == $past(r_count)))
        else $error("refused request changed the count");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_valid && (r_count_out == CNT_W'(r_count))))
        else $error("result beat missing or count mismatch");

    a_error_zero_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error) |-> (r_word_out == '0))
        else $error("refused request returned a nonzero word");

endmodule

### sim/positional_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking bench for the positional list store. A driver streams
// insert, remove and read requests in random bursts. A mirror of the list
// predicts each result beat. A monitor takes the results under a stall
// pattern of its own and checks them field by field against the mirror.
// ----------------------------------------------------------------------------
module positional_list_store_tb
    import pls_pkg::*;
;

    localparam int CAP          = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_MAX     = 10;

    // The package enum stops at read; the fourth code is refused by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        bit                drain_first;  // hold this beat until every reply is in
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              err;
        logic [CNT_W-1:0]  cnt;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [1:0] opcode, [6:2] position, [38:7] word_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // [31:0] word_out, [36:32] count_out
    logic        m_axis_tuser;   // [0] error

    t_request drive_req = '{default: '0};

    t_request request_q[$];
    t_reply   awaited_replies[$];

    // Mirror of the list contents
    logic [DATA_W-1:0] mirror_words[CAP];
    int                mirror_len = 0;

    int gen_len    = 0;   // list length as the stimulus generator sees it
    int n_sent     = 0;
    int n_checked  = 0;
    int total_reqs = 0;
    int failures   = 0;
    int cycles     = 0;
    int n_refused  = 0;
    int n_full     = 0;
    int n_empty    = 0;

    int burst_left = 1;
    int gap_left   = 0;
    int ready_mode = 0;
    int mode_left  = 0;
    int ready_tick = 0;

    assign s_axis_tdata = {1'b0, drive_req.word, drive_req.pos, drive_req.op};

    positional_list_store #(
        .CAPACITY   (CAP),
        .WORD_WIDTH (DATA_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the mirror and return the reply it must produce
    function automatic t_reply list_apply(t_request rq);
        t_reply r;
        int     i;
        r = '0;
        case (rq.op)
            OP_INSERT: begin
                if (rq.pos > mirror_len || mirror_len >= CAP) begin
                    r.err = 1'b1;
                end else begin
                    for (i = mirror_len; i > rq.pos; i--)
                        mirror_words[i] = mirror_words[i-1];
                    mirror_words[rq.pos] = rq.word;
                    mirror_len++;
                end
            end
            OP_REMOVE: begin
                if (rq.pos >= mirror_len) begin
                    r.err = 1'b1;
                end else begin
                    for (i = rq.pos; i + 1 < mirror_len; i++)
                        mirror_words[i] = mirror_words[i+1];
                    mirror_len--;
                end
            end
            OP_READ: begin
                if (rq.pos >= mirror_len)
                    r.err = 1'b1;
                else
                    r.word = mirror_words[rq.pos];
            end
            default: r.err = 1'b1;
        endcase
        r.cnt = mirror_len[CNT_W-1:0];
        return r;
    endfunction

    task automatic log_miss(input string msg);
        failures++;
        if (failures <= SHOW_MAX)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic add_req(input logic [1:0] op, input int pos, input logic [31:0] word,
                           input bit drain);
        t_request rq;
        rq.op          = op;
        rq.pos         = pos[POS_W-1:0];
        rq.word        = word;
        rq.drain_first = drain;
        request_q.push_back(rq);
        // track the length only to steer positions toward the live range
        case (op)
            OP_INSERT: if (pos <= gen_len && gen_len < CAP) gen_len++;
            OP_REMOVE: if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // Driver: present one beat at a time, hold it until taken, idle in gaps
    always @(posedge i_clk) begin
        logic took;
        took = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (took) begin
                awaited_replies.push_back(list_apply(drive_req));
                n_sent <= n_sent + 1;
            end
            if (s_axis_tvalid && !took) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() == 0 ||
                         (request_q[0].drain_first && n_sent + took != n_checked)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                drive_req     <= request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
            end
        end
    end

    // Monitor: stall on its own pattern, check each taken result beat
    always @(posedge i_clk) begin
        t_reply want;
        logic   rdy;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                log_miss($sformatf("result beat with none awaited: tdata=%h tuser=%b",
                                   m_axis_tdata, m_axis_tuser));
            end else begin
                want = awaited_replies.pop_front();
                n_checked <= n_checked + 1;
                if (m_axis_tdata[31:0] !== want.word)
                    log_miss($sformatf("reply %0d word_out: want %h got %h",
                                       n_checked, want.word, m_axis_tdata[31:0]));
                if (m_axis_tuser !== want.err)
                    log_miss($sformatf("reply %0d error: want %b got %b",
                                       n_checked, want.err, m_axis_tuser));
                if (m_axis_tdata[36:32] !== want.cnt)
                    log_miss($sformatf("reply %0d count_out: want %0d got %0d",
                                       n_checked, want.cnt, m_axis_tdata[36:32]));
                if (want.err) n_refused++;
                if (want.cnt == CAP) n_full++;
                if (want.cnt == 0) n_empty++;
            end
        end
        if (mode_left <= 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            default: rdy = (ready_tick % 6 == 0);
        endcase
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d replies checked",
                     cycles, n_checked, total_reqs);
            $display("** positional_list_store: FAILED **");
            $finish;
        end
    end

    initial begin
        int          k, j, mode, run, ins_share, pos, pick;
        logic [1:0]  op;
        logic [31:0] word;

        // Directed: empty list refusals, unused code, fill to full, edges
        add_req(OP_READ,   0, 32'h0, 1'b0);
        add_req(OP_REMOVE, 0, 32'h0, 1'b0);
        add_req(OP_INSERT, 1, 32'h1, 1'b0);           // past the end
        add_req(OP_UNUSED, 31, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_INSERT, 0, 32'h0, 1'b0);
        add_req(OP_INSERT, 1, 32'hFFFF_FFFF, 1'b0);   // append
        add_req(OP_INSERT, 0, 32'hA5A5_A5A5, 1'b0);   // front
        add_req(OP_INSERT, 1, 32'h1234_5678, 1'b0);   // middle
        for (k = 0; k < 12; k++)
            add_req(OP_INSERT, $urandom_range(0, gen_len), $urandom, 1'b0);
        add_req(OP_INSERT, 0, 32'hDEAD_BEEF, 1'b0);   // list full
        add_req(OP_INSERT, 17, 32'h5A5A_5A5A, 1'b0);  // full and past the end
        add_req(OP_READ,   0, 32'h0, 1'b0);           // first
        add_req(OP_READ,   15, 32'h0, 1'b0);          // last
        add_req(OP_READ,   16, 32'h0, 1'b0);          // past the end
        add_req(OP_REMOVE, 15, 32'h0, 1'b0);
        add_req(OP_REMOVE, 0, 32'h0, 1'b0);

        // Random: runs that grow, shrink or hold the list, with some noise
        k = 0;
        while (k < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 2);
            run       = $urandom_range(20, 60);
            ins_share = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
            for (j = 0; j < run && k < RANDOM_ITEMS; j++, k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    op  = 2'($urandom_range(0, 3));
                    pos = $urandom_range(0, 31);
                end else begin
                    if ($urandom_range(0, 99) < ins_share)
                        op = OP_INSERT;
                    else
                        op = $urandom_range(0, 1) ? OP_REMOVE : OP_READ;
                    if (op == OP_INSERT)
                        pos = $urandom_range(0, gen_len);
                    else
                        pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
                end
                pick = $urandom_range(0, 9);
                word = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                add_req(op, pos, word, (k % 400) == 0);
            end
        end
        total_reqs = request_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_checked != total_reqs) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (awaited_replies.size() != 0)
            log_miss($sformatf("%0d replies never arrived", awaited_replies.size()));

        $display("Ran %0d list requests, %0d refused; list full after %0d, empty after %0d.",
                 total_reqs, n_refused, n_full, n_empty);
        $display("Mismatches: %0d (first %0d shown).", failures, SHOW_MAX);
        if (failures == 0)
            $display("** positional_list_store: PASSED **");
        else
            $display("** positional_list_store: FAILED **");
        $finish;
    end

endmodule
